// ----- design/cef_pkg.sv -----
package cef_pkg;

    // Internal word widths of the datapath.
    localparam int XY_W = 37;
    localparam int Z_W  = 34;
    localparam int CS_W = 34;
    localparam int P_W  = 31;
    localparam int L_W  = 66;

    // Angle and gain constants, radians and gain in Q30.
    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CS_W-1:0] INV_GAIN    = 34'sd652032874;

    // Angle output clipping range.
    localparam logic signed [Z_W:0] ANG_MAX = 35'sd262143;
    localparam logic signed [Z_W:0] ANG_MIN = -35'sd262144;

    // Word moved from the front to the back: pre-rotated CORDIC vector.
    typedef struct packed {
        logic signed [31:0]     a;
        logic signed [31:0]     d;
        logic signed [32:0]     q;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } vec_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m11;
        logic signed [31:0] lmin;
        logic signed [31:0] lmax;
        logic signed [18:0] ang;
    } out_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] one;
        one = 1;
        case (i)
            0: atan_q30 = 34'sd843314857;
            1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043837;
            3: atan_q30 = 34'sd133525159;
            4: atan_q30 = 34'sd67021687;
            5: atan_q30 = 34'sd33543516;
            6: atan_q30 = 34'sd16775851;
            7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194283;
            9: atan_q30 = 34'sd2097149;
            default: atan_q30 = (i <= 30) ? (one <<< (30 - i)) : '0;
        endcase
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
        begin
            sat32 = 32'sh7fffffff;
        end
        else if (v < -68'sd2147483648)
        begin
            sat32 = 32'sh80000000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ----- design/cef_queue.sv -----
module cef_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/cef_front.sv -----
module cef_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    input  logic signed [31:0] in_c,
    input  logic signed [31:0] in_d,
    output cef_pkg::vec_t      word,
    output logic               word_push,
    input  logic               word_full
);

    logic          valid_reg, valid_next;
    cef_pkg::vec_t word_reg, word_next;
    logic          accept;
    logic          moved;
    logic signed [32:0] dx;
    logic signed [32:0] qs;
    logic signed [33:0] ny;

    assign moved     = valid_reg && !word_full;
    assign full      = valid_reg && word_full;
    assign accept    = push && !full;
    assign word      = word_reg;
    assign word_push = valid_reg;

    // Form the vector (d - a, -(b + c)) and turn it by pi when x is negative.
    always_comb
    begin
        dx = 33'(in_d) - 33'(in_a);
        qs = 33'(in_b) + 33'(in_c);
        ny = -34'(qs);
        word_next.a = in_a;
        word_next.d = in_d;
        word_next.q = qs;
        if (dx < 0)
        begin
            word_next.x = -cef_pkg::XY_W'(dx);
            word_next.y = -cef_pkg::XY_W'(ny);
            word_next.z = (ny > 0) ? cef_pkg::PI_Q30 : -cef_pkg::PI_Q30;
        end
        else
        begin
            word_next.x = cef_pkg::XY_W'(dx);
            word_next.y = cef_pkg::XY_W'(ny);
            word_next.z = '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (moved)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ----- design/cef_back.sv -----
module cef_back #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cef_pkg::vec_t in_word,
    input  logic          in_valid,
    output logic          in_pop,
    input  logic [30:0]   eig_floor,
    output cef_pkg::out_t out_word,
    output logic          out_push,
    input  logic          out_full
);

    localparam int N   = CORDIC_STEPS;
    localparam int ZW  = cef_pkg::Z_W;
    localparam int CW  = cef_pkg::CS_W;
    localparam int PW  = cef_pkg::P_W;
    localparam int LW  = cef_pkg::L_W;
    localparam int ASH = 30 - FRAC_BITS;
    localparam logic [ZW:0] ANG_RND = ({{ZW{1'b0}}, 1'b1} << ASH) >> 1;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] d;
        logic signed [32:0] q;
        logic signed [ZW-1:0] t;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] d;
        logic signed [32:0] q;
        logic signed [ZW-1:0] t;
        logic signed [PW-1:0] cc;
        logic signed [PW-1:0] ss;
        logic signed [PW-1:0] cs;
    } trig_t;

    typedef struct packed {
        logic signed [LW-1:0] pa;
        logic signed [LW-1:0] pd;
        logic signed [LW-1:0] pq;
        logic signed [LW-1:0] pa2;
        logic signed [LW-1:0] pd2;
        logic signed [ZW-1:0] t;
        logic signed [PW-1:0] cc;
        logic signed [PW-1:0] ss;
        logic signed [PW-1:0] cs;
    } prod_t;

    typedef struct packed {
        logic signed [LW-1:0] lmax;
        logic signed [LW-1:0] lmin;
        logic signed [ZW-1:0] t;
        logic signed [PW-1:0] cc;
        logic signed [PW-1:0] ss;
        logic signed [PW-1:0] cs;
    } sum_t;

    typedef struct packed {
        logic signed [31:0] lmax;
        logic signed [31:0] lmin;
        logic signed [ZW-1:0] t;
        logic signed [PW-1:0] cc;
        logic signed [PW-1:0] ss;
        logic signed [PW-1:0] cs;
    } eig_t;

    typedef struct packed {
        logic signed [31:0] l1;
        logic signed [31:0] l2;
        logic signed [32:0] dl;
        logic signed [31:0] lmax;
        logic signed [31:0] lmin;
        logic signed [18:0] ang;
        logic signed [PW-1:0] cc;
        logic signed [PW-1:0] ss;
        logic signed [PW-1:0] cs;
    } flr_t;

    typedef struct packed {
        logic signed [63:0] p00a;
        logic signed [63:0] p00b;
        logic signed [63:0] p01;
        logic signed [63:0] p11a;
        logic signed [63:0] p11b;
        logic signed [31:0] lmax;
        logic signed [31:0] lmin;
        logic signed [18:0] ang;
    } mat_t;

    cef_pkg::vec_t vec_reg  [0:N];
    cef_pkg::vec_t vec_step [0:N-1];
    logic          vv_reg   [0:N];
    rot_t          rot_reg  [0:N];
    rot_t          rot_step [0:N-1];
    logic          rv_reg   [0:N];

    trig_t         m1_reg, m1_next;
    prod_t         m2_reg, m2_next;
    sum_t          m3_reg, m3_next;
    eig_t          m4_reg, m4_next;
    flr_t          m5_reg, m5_next;
    mat_t          m6_reg, m6_next;
    cef_pkg::out_t m7_reg, m7_next;
    logic [6:0]    mv_reg;
    logic          adv;

    // The whole back pipeline holds only when a finished word cannot be stored.
    assign adv      = !(out_full && mv_reg[6]);
    assign in_pop   = adv && in_valid;
    assign out_push = adv && mv_reg[6];
    assign out_word = m7_reg;

    // Vectoring CORDIC stages: drive y to zero, accumulate the angle.
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        always_comb
        begin
            vec_step[i] = vec_reg[i];
            if (vec_reg[i].y > 0)
            begin
                vec_step[i].x = vec_reg[i].x + (vec_reg[i].y >>> i);
                vec_step[i].y = vec_reg[i].y - (vec_reg[i].x >>> i);
                vec_step[i].z = vec_reg[i].z + cef_pkg::atan_q30(i);
            end
            else if (vec_reg[i].y < 0)
            begin
                vec_step[i].x = vec_reg[i].x - (vec_reg[i].y >>> i);
                vec_step[i].y = vec_reg[i].y + (vec_reg[i].x >>> i);
                vec_step[i].z = vec_reg[i].z - cef_pkg::atan_q30(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vec_reg[i+1] <= vec_step[i];
            end
        end
    end

    // Rotation CORDIC stages: turn (1/K, 0) by theta.
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        always_comb
        begin
            rot_step[i] = rot_reg[i];
            if (rot_reg[i].z >= 0)
            begin
                rot_step[i].c = rot_reg[i].c - (rot_reg[i].s >>> i);
                rot_step[i].s = rot_reg[i].s + (rot_reg[i].c >>> i);
                rot_step[i].z = rot_reg[i].z - cef_pkg::atan_q30(i);
            end
            else
            begin
                rot_step[i].c = rot_reg[i].c + (rot_reg[i].s >>> i);
                rot_step[i].s = rot_reg[i].s - (rot_reg[i].c >>> i);
                rot_step[i].z = rot_reg[i].z + cef_pkg::atan_q30(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rot_reg[i+1] <= rot_step[i];
            end
        end
    end

    // Entry of both CORDIC chains.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg[0]   <= in_word;
            rot_reg[0].a <= vec_reg[N].a;
            rot_reg[0].d <= vec_reg[N].d;
            rot_reg[0].q <= vec_reg[N].q;
            rot_reg[0].t <= vec_reg[N].z >>> 1;
            rot_reg[0].z <= vec_reg[N].z >>> 1;
            rot_reg[0].c <= cef_pkg::INV_GAIN;
            rot_reg[0].s <= '0;
        end
    end

    // Squares and cross product of cos and sin, rounded to Q28.
    always_comb
    begin
        logic signed [67:0] pcc;
        logic signed [67:0] pss;
        logic signed [67:0] pcs;
        pcc = rot_reg[N].c * rot_reg[N].c;
        pss = rot_reg[N].s * rot_reg[N].s;
        pcs = rot_reg[N].c * rot_reg[N].s;
        pcc = (pcc + 68'sd2147483648) >>> 32;
        pss = (pss + 68'sd2147483648) >>> 32;
        pcs = (pcs + 68'sd2147483648) >>> 32;
        m1_next.a  = rot_reg[N].a;
        m1_next.d  = rot_reg[N].d;
        m1_next.q  = rot_reg[N].q;
        m1_next.t  = rot_reg[N].t;
        m1_next.cc = pcc[PW-1:0];
        m1_next.ss = pss[PW-1:0];
        m1_next.cs = pcs[PW-1:0];
    end

    // Products of the matrix entries with the trig terms.
    always_comb
    begin
        m2_next.pa  = m1_reg.a * m1_reg.cc;
        m2_next.pd  = m1_reg.d * m1_reg.ss;
        m2_next.pq  = m1_reg.q * m1_reg.cs;
        m2_next.pa2 = m1_reg.a * m1_reg.ss;
        m2_next.pd2 = m1_reg.d * m1_reg.cc;
        m2_next.t   = m1_reg.t;
        m2_next.cc  = m1_reg.cc;
        m2_next.ss  = m1_reg.ss;
        m2_next.cs  = m1_reg.cs;
    end

    // Raw eigenvalue sums.
    always_comb
    begin
        m3_next.lmax = m2_reg.pa + m2_reg.pd + m2_reg.pq;
        m3_next.lmin = m2_reg.pa2 + m2_reg.pd2 - m2_reg.pq;
        m3_next.t    = m2_reg.t;
        m3_next.cc   = m2_reg.cc;
        m3_next.ss   = m2_reg.ss;
        m3_next.cs   = m2_reg.cs;
    end

    // Order the eigenvalues, turning theta by a quarter when they swap.
    always_comb
    begin
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        if (m3_reg.lmax < m3_reg.lmin)
        begin
            hi         = m3_reg.lmin;
            lo         = m3_reg.lmax;
            m4_next.t  = m3_reg.t + cef_pkg::HALF_PI_Q30;
            m4_next.cc = m3_reg.ss;
            m4_next.ss = m3_reg.cc;
            m4_next.cs = -m3_reg.cs;
        end
        else
        begin
            hi         = m3_reg.lmax;
            lo         = m3_reg.lmin;
            m4_next.t  = m3_reg.t;
            m4_next.cc = m3_reg.cc;
            m4_next.ss = m3_reg.ss;
            m4_next.cs = m3_reg.cs;
        end
        m4_next.lmax = cef_pkg::sat32((hi + 68'sd134217728) >>> 28);
        m4_next.lmin = cef_pkg::sat32((lo + 68'sd134217728) >>> 28);
    end

    // Apply the floor and scale the angle to the output format.
    always_comb
    begin
        logic signed [31:0] fl;
        logic signed [ZW:0] tt;
        fl = {1'b0, eig_floor};
        m5_next.l1   = (m4_reg.lmax < fl) ? fl : m4_reg.lmax;
        m5_next.l2   = (m4_reg.lmin < fl) ? fl : m4_reg.lmin;
        m5_next.dl   = 33'(m5_next.l1) - 33'(m5_next.l2);
        m5_next.lmax = m4_reg.lmax;
        m5_next.lmin = m4_reg.lmin;
        m5_next.cc   = m4_reg.cc;
        m5_next.ss   = m4_reg.ss;
        m5_next.cs   = m4_reg.cs;
        tt = (35'(m4_reg.t) + $signed(ANG_RND)) >>> ASH;
        if (tt > cef_pkg::ANG_MAX)
        begin
            m5_next.ang = cef_pkg::ANG_MAX[18:0];
        end
        else if (tt < cef_pkg::ANG_MIN)
        begin
            m5_next.ang = cef_pkg::ANG_MIN[18:0];
        end
        else
        begin
            m5_next.ang = tt[18:0];
        end
    end

    // Products of the rebuild R * diag(l1, l2) * R^T.
    always_comb
    begin
        m6_next.p00a = m5_reg.l1 * m5_reg.cc;
        m6_next.p00b = m5_reg.l2 * m5_reg.ss;
        m6_next.p01  = m5_reg.dl * m5_reg.cs;
        m6_next.p11a = m5_reg.l1 * m5_reg.ss;
        m6_next.p11b = m5_reg.l2 * m5_reg.cc;
        m6_next.lmax = m5_reg.lmax;
        m6_next.lmin = m5_reg.lmin;
        m6_next.ang  = m5_reg.ang;
    end

    // Final sums, rounded back to the input scale and saturated.
    always_comb
    begin
        logic signed [67:0] s00;
        logic signed [67:0] s01;
        logic signed [67:0] s11;
        s00 = m6_reg.p00a + m6_reg.p00b;
        s01 = m6_reg.p01;
        s11 = m6_reg.p11a + m6_reg.p11b;
        m7_next.m00  = cef_pkg::sat32((s00 + 68'sd134217728) >>> 28);
        m7_next.m01  = cef_pkg::sat32((s01 + 68'sd134217728) >>> 28);
        m7_next.m11  = cef_pkg::sat32((s11 + 68'sd134217728) >>> 28);
        m7_next.lmin = m6_reg.lmin;
        m7_next.lmax = m6_reg.lmax;
        m7_next.ang  = m6_reg.ang;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
            m5_reg <= m5_next;
            m6_reg <= m6_next;
            m7_reg <= m7_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                vv_reg[k] <= 1'b0;
                rv_reg[k] <= 1'b0;
            end
            mv_reg <= '0;
        end
        else if (adv)
        begin
            vv_reg[0] <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                vv_reg[k+1] <= vv_reg[k];
                rv_reg[k+1] <= rv_reg[k];
            end
            rv_reg[0] <= vv_reg[N];
            mv_reg    <= {mv_reg[5:0], rv_reg[N]};
        end
    end

endmodule

// ----- design/covariance_eigenvalue_floor.sv -----
// Eigenvalue floor for symmetric 2x2 covariance matrices in signed Q16.16.
// Input side is a queue: present in_a..in_d with push; the word is taken
// at a clock edge where push is high and full is low.
// Result side is a queue: while empty is low the oldest result is on
// out_a..out_d, eig_min, eig_max and angle; pop takes it.
// The floor register is written through cfg_valid/cfg_ready/cfg_eig_floor;
// cfg_ready is always high. Write it only while no matrix is in flight.
// Accepts one matrix per cycle while full is low. The two pipelined
// CORDIC chains (one stage per iteration) are followed by seven multiply,
// sum and round stages.
// A four-word queue parts the input register from the arithmetic pipeline.
// When the receiver stalls, the two-word result queue fills, the pipeline
// holds, the middle queue fills and full rises; nothing is lost.
// Reset clears all queues and valid bits and sets the floor to zero.
module covariance_eigenvalue_floor #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] in_a,
    input  logic signed [31:0] in_b,
    input  logic signed [31:0] in_c,
    input  logic signed [31:0] in_d,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] out_a,
    output logic signed [31:0] out_b,
    output logic signed [31:0] out_c,
    output logic signed [31:0] out_d,
    output logic signed [31:0] eig_min,
    output logic signed [31:0] eig_max,
    output logic signed [18:0] angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_eig_floor
);

    localparam int VW = $bits(cef_pkg::vec_t);
    localparam int OW = $bits(cef_pkg::out_t);

    logic [30:0]   floor_reg;
    cef_pkg::vec_t f_word;
    logic          f_push;
    logic          mid_full;
    logic          mid_empty;
    logic          mid_pop;
    logic [VW-1:0] mid_rdata;
    cef_pkg::out_t b_word;
    logic          b_push;
    logic          res_full;
    logic [OW-1:0] res_rdata;
    cef_pkg::out_t res_word;

    // Floor register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            floor_reg <= cfg_eig_floor;
        end
    end

    cef_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_c      (in_c),
        .in_d      (in_d),
        .word      (f_word),
        .word_push (f_push),
        .word_full (mid_full)
    );

    cef_queue #(
        .WIDTH (VW),
        .DEPTH (4)
    ) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_word),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    cef_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (cef_pkg::vec_t'(mid_rdata)),
        .in_valid  (!mid_empty),
        .in_pop    (mid_pop),
        .eig_floor (floor_reg),
        .out_word  (b_word),
        .out_push  (b_push),
        .out_full  (res_full)
    );

    cef_queue #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_res (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_push),
        .wdata (b_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Result fields.
    assign res_word = cef_pkg::out_t'(res_rdata);
    assign out_a    = res_word.m00;
    assign out_b    = res_word.m01;
    assign out_c    = res_word.m01;
    assign out_d    = res_word.m11;
    assign eig_min  = res_word.lmin;
    assign eig_max  = res_word.lmax;
    assign angle    = res_word.ang;

endmodule

// ----- tb/sv/tb_covariance_eigenvalue_floor.sv -----
`timescale 1ns / 1ps

module tb_covariance_eigenvalue_floor;

    localparam int STEPS   = 16;
    localparam int FRAC    = 16;
    localparam int LATENCY = 2 * STEPS + 11;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } matrix_t;

    typedef struct {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m11;
        logic signed [31:0] lmin;
        logic signed [31:0] lmax;
        logic signed [18:0] ang;
    } floored_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] in_a;
    logic signed [31:0] in_b;
    logic signed [31:0] in_c;
    logic signed [31:0] in_d;
    logic               empty;
    logic               pop;
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic signed [31:0] out_d;
    logic signed [31:0] eig_min;
    logic signed [31:0] eig_max;
    logic signed [18:0] angle;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [30:0]        cfg_eig_floor;

    matrix_t  pending_matrices[$];
    floored_t expected_floored[$];
    longint   floor_model;
    int       send_idle_pct;
    int       stall_pct;
    bit       word_taken;
    int       fail_count;

    covariance_eigenvalue_floor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_a          (in_a),
        .in_b          (in_b),
        .in_c          (in_c),
        .in_d          (in_d),
        .empty         (empty),
        .pop           (pop),
        .out_a         (out_a),
        .out_b         (out_b),
        .out_c         (out_c),
        .out_d         (out_d),
        .eig_min       (eig_min),
        .eig_max       (eig_max),
        .angle         (angle),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_eig_floor (cfg_eig_floor)
    );

    // Clock with a 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Arctangent of 2^-i in Q30.
    function automatic longint atan_step(input int i);
        longint head[10];
        head = '{843314857, 497837829, 263043837, 133525159, 67021687,
                 33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    // Round to nearest by adding half an LSB and shifting toward minus infinity.
    function automatic longint round_shift(input longint v, input int sh);
        if (sh == 0)
            return v;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Predicts the floored matrix, eigenvalues and angle of one input word.
    function automatic floored_t floor_eigenvalues(input matrix_t m, input longint fl);
        floored_t r;
        longint a, d, q, x, y, z, t, xn, c, s, cc, ss, cs, tmp;
        longint lmax, lmin, l1, l2, ang;
        a = m.a;
        d = m.d;
        q = longint'(m.b) + longint'(m.c);
        x = d - a;
        y = -q;
        z = 0;
        // Vectoring pass; a negative x is turned by pi first.
        if (x < 0)
        begin
            z = (y > 0) ? longint'(cef_pkg::PI_Q30) : -longint'(cef_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                x  = xn;
                z += atan_step(i);
            end
            else if (y < 0)
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                x  = xn;
                z -= atan_step(i);
            end
        end
        t = z >>> 1;
        // Rotation pass gives cosine and sine of the half angle.
        c = cef_pkg::INV_GAIN;
        s = 0;
        z = t;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                xn = c - (s >>> i);
                s  = s + (c >>> i);
                c  = xn;
                z -= atan_step(i);
            end
            else
            begin
                xn = c + (s >>> i);
                s  = s - (c >>> i);
                c  = xn;
                z += atan_step(i);
            end
        end
        cc = round_shift(c * c, 32);
        ss = round_shift(s * s, 32);
        cs = round_shift(c * s, 32);
        lmax = a * cc + d * ss + q * cs;
        lmin = a * ss + d * cc - q * cs;
        // Out of order eigenvalues are swapped and the angle turns by pi/2.
        if (lmax < lmin)
        begin
            tmp  = lmax;
            lmax = lmin;
            lmin = tmp;
            t   += longint'(cef_pkg::HALF_PI_Q30);
            tmp  = cc;
            cc   = ss;
            ss   = tmp;
            cs   = -cs;
        end
        lmax = clip32(round_shift(lmax, 28));
        lmin = clip32(round_shift(lmin, 28));
        l1 = (lmax < fl) ? fl : lmax;
        l2 = (lmin < fl) ? fl : lmin;
        r.m00  = clip32(round_shift(l1 * cc + l2 * ss, 28));
        r.m01  = clip32(round_shift((l1 - l2) * cs, 28));
        r.m11  = clip32(round_shift(l1 * ss + l2 * cc, 28));
        r.lmin = lmin;
        r.lmax = lmax;
        ang = round_shift(t, (FRAC < 30) ? 30 - FRAC : 0);
        if (ang > 262143)
            ang = 262143;
        if (ang < -262144)
            ang = -262144;
        r.ang = ang[18:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Driver: presents matrix words and pops results at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || word_taken)
            begin
                word_taken = 1'b0;
                if (pending_matrices.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    matrix_t m;
                    m = pending_matrices.pop_front();
                    in_a <= m.a;
                    in_b <= m.b;
                    in_c <= m.c;
                    in_d <= m.d;
                    push <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: predicts on accepted input words, checks accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                matrix_t m;
                m.a = in_a;
                m.b = in_b;
                m.c = in_c;
                m.d = in_d;
                expected_floored.push_back(floor_eigenvalues(m, floor_model));
                word_taken = 1'b1;
            end
            if (pop && !empty)
            begin
                if (expected_floored.size() == 0)
                begin
                    $error("result word with no matrix outstanding");
                    fail_count++;
                end
                else
                begin
                    floored_t e;
                    e = expected_floored.pop_front();
                    check_field("out_a", e.m00, out_a);
                    check_field("out_b", e.m01, out_b);
                    check_field("out_c", e.m01, out_c);
                    check_field("out_d", e.m11, out_d);
                    check_field("eig_min", e.lmin, eig_min);
                    check_field("eig_max", e.lmax, eig_max);
                    check_field("angle", e.ang, angle);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #(20 * 400000);
        $display("tb_covariance_eigenvalue_floor NOT OK");
        $finish;
    end

    task automatic add_matrix(input logic signed [31:0] a, input logic signed [31:0] b,
                              input logic signed [31:0] c, input logic signed [31:0] d);
        matrix_t m;
        m.a = a;
        m.b = b;
        m.c = c;
        m.d = d;
        pending_matrices.push_back(m);
    endtask

    // Random matrices: half covariance-like, some small, some full range.
    task automatic add_random(input int count);
        logic signed [31:0] a, b, c, d;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            a = $urandom;
            b = $urandom;
            c = $urandom;
            d = $urandom;
            if (kind < 5)
            begin
                a = $urandom_range(32'h00ff_ffff);
                d = $urandom_range(32'h00ff_ffff);
                b = $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
                c = ($urandom_range(3) == 0) ? b + $signed($urandom_range(15)) : b;
            end
            else if (kind < 7)
            begin
                a = $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
                b = $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
                c = $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
                d = ($urandom_range(3) == 0) ? a : $signed($urandom_range(32'h0003_ffff))
                    - 32'sh0002_0000;
                if ($urandom_range(3) == 0)
                    c = -b;
            end
            add_matrix(a, b, c, d);
        end
    endtask

    // Waits until every word has been taken and every result checked.
    task automatic wait_drained();
        while (pending_matrices.size() != 0 || push || expected_floored.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_floor(input logic [30:0] value);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        cfg_eig_floor <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        floor_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [30:0] fl, input int idle, input int stall,
                             input int count);
        write_floor(fl);
        send_idle_pct = idle;
        stall_pct     = stall;
        add_random(count);
        wait_drained();
    endtask

    // Stimulus.
    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        in_a          = '0;
        in_b          = '0;
        in_c          = '0;
        in_d          = '0;
        cfg_valid     = 1'b0;
        cfg_eig_floor = '0;
        floor_model   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        word_taken    = 1'b0;
        fail_count    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words with the floor at its reset value.
        add_matrix(0, 0, 0, 0);
        add_matrix(32'sh0001_0000, 0, 0, 32'sh0001_0000);
        add_matrix(32'sh0003_0000, 0, 0, 32'sh0001_0000);
        add_matrix(32'sh0001_0000, 0, 0, 32'sh0003_0000);
        add_matrix(32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
        add_matrix(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000);
        add_matrix(32'sh0002_0000, -32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000);
        add_matrix(32'sh0005_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        add_matrix(32'sh0005_0000, -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
        add_matrix(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_matrix(32'sh7fffffff, 0, 0, 32'sh80000000);
        add_matrix(32'sh80000000, 0, 0, 32'sh7fffffff);
        add_matrix(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        add_matrix(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        add_matrix(-32'sh0001_0000, 0, 0, -32'sh0002_0000);
        add_matrix(0, 1, 0, 0);
        add_matrix(0, -1, 0, 0);
        add_matrix(1, 0, 0, 0);
        add_matrix(32'sh0000_8000, 32'sh7fffffff, 32'sh80000000, 32'sh0000_4000);
        add_matrix(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
        wait_drained();

        run_phase(31'd0, 0, 0, 300);
        run_phase(31'h7fffffff, 0, 0, 150);
        run_phase(31'h0001_0000, 83, 0, 300);
        run_phase(31'd1, 0, 83, 300);
        run_phase(31'($urandom), 11, 11, 300);
        run_phase(31'h0000_4000, 0, 0, 300);

        if (fail_count == 0 && expected_floored.size() == 0)
        begin
            $display("tb_covariance_eigenvalue_floor OK");
        end
        else
        begin
            $display("tb_covariance_eigenvalue_floor NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/cef_pkg.sv
design/cef_queue.sv
design/cef_front.sv
design/cef_back.sv
design/covariance_eigenvalue_floor.sv
tb/sv/tb_covariance_eigenvalue_floor.sv
